// File: hdl/fixed_function_fragment_ops_macros.svh
// Assertion macros for the fragment operations block
`ifndef FIXED_FUNCTION_FRAGMENT_OPS_MACROS_SVH
`define FIXED_FUNCTION_FRAGMENT_OPS_MACROS_SVH
`ifndef ASSERT_OFF
`define FFO_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFO_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFO_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FFO_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: hdl/ffo_pkg.sv
`default_nettype none
package ffo_pkg;
   localparam logic [1:0] ENV_REPLACE  = 2'd0;
   localparam logic [1:0] ENV_MODULATE = 2'd1;
   localparam logic [1:0] ENV_DECAL    = 2'd2;

   localparam logic [3:0] AT_NEVER    = 4'd1;
   localparam logic [3:0] AT_LESS     = 4'd3;
   localparam logic [3:0] AT_LEQUAL   = 4'd4;
   localparam logic [3:0] AT_EQUAL    = 4'd5;
   localparam logic [3:0] AT_GEQUAL   = 4'd6;
   localparam logic [3:0] AT_GREATER  = 4'd7;
   localparam logic [3:0] AT_NOTEQUAL = 4'd8;

   localparam logic [3:0] BF_ONE      = 4'd1;
   localparam logic [3:0] BF_SRC      = 4'd2;
   localparam logic [3:0] BF_DST      = 4'd3;
   localparam logic [3:0] BF_INV_SRC  = 4'd4;
   localparam logic [3:0] BF_INV_DST  = 4'd5;
   localparam logic [3:0] BF_SRC_A    = 4'd6;
   localparam logic [3:0] BF_INV_SRCA = 4'd7;
   localparam logic [3:0] BF_DST_A    = 4'd8;
   localparam logic [3:0] BF_INV_DSTA = 4'd9;
   localparam logic [3:0] BF_SAT      = 4'd10;

   localparam logic [2:0] REG_UNITS   = 3'd0;
   localparam logic [2:0] REG_ENV0    = 3'd1;
   localparam logic [2:0] REG_ENV1    = 3'd2;
   localparam logic [2:0] REG_ATMODE  = 3'd3;
   localparam logic [2:0] REG_AREF    = 3'd4;
   localparam logic [2:0] REG_SRCF    = 3'd5;
   localparam logic [2:0] REG_DSTF    = 3'd6;
   localparam logic [2:0] REG_WMASK   = 3'd7;

   typedef struct packed {
      logic [1:0] units;
      logic [1:0] env0;
      logic [1:0] env1;
      logic [3:0] at_mode;
      logic [7:0] aref;
      logic [3:0] srcf;
      logic [3:0] dstf;
      logic [3:0] wmask;
   } cfg_type;

   // round(x/255) for x < 2^17: (x+127)/255 via reciprocal and one correction
   function automatic logic [8:0] un_div(input logic [16:0] x);
      logic [17:0] y;
      logic [17:0] q;
      logic [17:0] r;
      begin
         y = {1'b0, x} + 18'd127;
         q = 18'((36'(y) * 36'd257) >> 16);
         r = y - 18'(q * 18'd255);
         if (r >= 18'd255) begin
            q = q + 18'd1;
         end
         un_div = q[8:0];
      end
   endfunction

   // one texture environment on one channel
   function automatic logic [7:0] env_chan(input logic [1:0] mode, input logic [7:0] c,
                                           input logic [7:0] t, input logic [7:0] ta,
                                           input logic is_alpha);
      logic [16:0] s;
      logic [8:0]  q;
      begin
         case (mode)
            ENV_MODULATE: s = {9'd0, c} * {9'd0, t};
            ENV_DECAL:    s = {9'd0, c} * {9'd0, 8'd255 - ta} + {9'd0, t} * {9'd0, ta};
            default:      s = 17'd0;
         endcase
         q = un_div(s);
         case (mode)
            ENV_REPLACE:  env_chan = t;
            ENV_MODULATE: env_chan = q[7:0];
            ENV_DECAL:    env_chan = is_alpha ? c : q[7:0];
            default:      env_chan = c;
         endcase
      end
   endfunction

   function automatic logic [7:0] factor(input logic [3:0] f, input logic [1:0] i,
                                         input logic [7:0] s, input logic [7:0] d,
                                         input logic [7:0] sa, input logic [7:0] da);
      begin
         case (f)
            BF_ONE:      factor = 8'd255;
            BF_SRC:      factor = s;
            BF_DST:      factor = d;
            BF_INV_SRC:  factor = 8'd255 - s;
            BF_INV_DST:  factor = 8'd255 - d;
            BF_SRC_A:    factor = sa;
            BF_INV_SRCA: factor = 8'd255 - sa;
            BF_DST_A:    factor = da;
            BF_INV_DSTA: factor = 8'd255 - da;
            BF_SAT: begin
               if (i == 2'd3) factor = 8'd255;
               else factor = (sa < 8'd255 - da) ? sa : 8'd255 - da;
            end
            default:     factor = 8'd0;
         endcase
      end
   endfunction
endpackage
`default_nettype wire

// File: hdl/ffo_if.sv
`default_nettype none
interface ffo_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frag_red;
   logic [7:0]  frag_green;
   logic [7:0]  frag_blue;
   logic [7:0]  frag_alpha;
   logic [31:0] texel_first;
   logic [31:0] texel_second;
   logic [31:0] dest_pixel;
   modport source (output valid, frag_red, frag_green, frag_blue, frag_alpha,
                   texel_first, texel_second, dest_pixel, input ready);
   modport sink (input valid, frag_red, frag_green, frag_blue, frag_alpha,
                 texel_first, texel_second, dest_pixel, output ready);
endinterface

interface ffo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;
   logic        covered;
   modport source (output valid, out_pixel, covered, input ready);
   modport sink (input valid, out_pixel, covered, output ready);
endinterface

interface ffo_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/ffo_env_stage.sv
`default_nettype none
// One texture unit environment stage, registered, with stall
module ffo_env_stage
   import ffo_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic        enable,
   input  wire logic [1:0]  mode,
   input  wire logic [31:0] color_in,
   input  wire logic [31:0] texel,
   input  wire logic [31:0] carry_in,
   output logic             out_valid,
   output logic [31:0]      color_out,
   output logic [31:0]      carry_out
);
   logic        valid_ff;
   logic [31:0] color_ff, color_in_c, carry_ff;

   always_comb begin
      color_in_c = color_in;
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            color_in_c[8*i +: 8] = env_chan(mode, color_in[8*i +: 8], texel[8*i +: 8],
                                            texel[31:24], i == 3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         color_ff <= color_in_c;
         carry_ff <= carry_in;
      end
   end

   assign out_valid = valid_ff;
   assign color_out = color_ff;
   assign carry_out = carry_ff;
endmodule
`default_nettype wire

// File: hdl/ffo_blend.sv
`default_nettype none
// Alpha test and blend: factor stage, then sum/round/mask stage
module ffo_blend
   import ffo_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   input  wire logic [31:0] color,
   input  wire logic [31:0] dest_pixel,
   output logic             out_valid,
   output logic [31:0]      out_pixel,
   output logic             covered
);
   logic [31:0] d;
   logic        cov_in;
   logic [15:0] sp_in [4];
   logic [15:0] dp_in [4];
   logic [15:0] sp_ff [4];
   logic [15:0] dp_ff [4];
   logic [31:0] d_ff;
   logic        cov_ff, v1_ff, v2_ff, cov2_ff;
   logic [31:0] o_in, o_ff;
   logic [8:0]  q;

   // destination in R,G,B,A order
   assign d = {dest_pixel[31:24], dest_pixel[7:0], dest_pixel[15:8], dest_pixel[23:16]};

   always_comb begin
      case (cfg.at_mode)
         AT_NEVER:    cov_in = 1'b0;
         AT_LESS:     cov_in = color[31:24] < cfg.aref;
         AT_LEQUAL:   cov_in = color[31:24] <= cfg.aref;
         AT_EQUAL:    cov_in = color[31:24] == cfg.aref;
         AT_GEQUAL:   cov_in = color[31:24] >= cfg.aref;
         AT_GREATER:  cov_in = color[31:24] > cfg.aref;
         AT_NOTEQUAL: cov_in = color[31:24] != cfg.aref;
         default:     cov_in = 1'b1;
      endcase
      for (int i = 0; i < 4; i++) begin
         sp_in[i] = factor(cfg.srcf, 2'(i), color[8*i +: 8], d[8*i +: 8], color[31:24],
                           d[31:24]) * color[8*i +: 8];
         dp_in[i] = factor(cfg.dstf, 2'(i), color[8*i +: 8], d[8*i +: 8], color[31:24],
                           d[31:24]) * d[8*i +: 8];
      end
   end

   // round the sum, clamp, apply write mask, pack BGRA
   always_comb begin
      o_in = '0;
      for (int i = 0; i < 4; i++) begin
         q = un_div(17'(sp_ff[i]) + 17'(dp_ff[i]));
         if (!cfg.wmask[i]) q = {1'b0, d_ff[8*i +: 8]};
         else if (q > 9'd255) q = 9'd255;
         case (i)
            0:       o_in[23:16] = q[7:0];
            1:       o_in[15:8]  = q[7:0];
            2:       o_in[7:0]   = q[7:0];
            default: o_in[31:24] = q[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         sp_ff   <= sp_in;
         dp_ff   <= dp_in;
         d_ff    <= d;
         cov_ff  <= cov_in;
         o_ff    <= o_in;
         cov2_ff <= cov_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_pixel = o_ff;
   assign covered   = cov2_ff;
endmodule
`default_nettype wire

// File: hdl/fixed_function_fragment_ops.sv
// Fixed-function fragment operations: texture env, alpha test, blend, mask.
// Pipeline: four register stages (two env stages, factor multiply stage,
// round/mask stage).
// Throughput: one item per cycle; the whole pipe advances whenever the
// output register is empty or taken, and freezes while rsp is stalled.
// Reset: synchronous, clears valid bits and loads register reset values.
`default_nettype none
`include "fixed_function_fragment_ops_macros.svh"
module fixed_function_fragment_ops
   import ffo_pkg::*;
#(
   parameter int TEXTURE_UNITS = 2
) (
   input wire logic clock,
   input wire logic reset,
   ffo_req_if.sink   req,
   ffo_rsp_if.source rsp,
   ffo_csr_if.sink   csr
);
   localparam logic [1:0] LIMIT = (TEXTURE_UNITS < 2) ? 2'(TEXTURE_UNITS) : 2'd2;

   cfg_type     cfg_ff;
   logic        advance;
   logic [1:0]  n_units;
   logic        v1, v2;
   logic [31:0] c0, c1, c2, dst1, dst2;

   assign csr.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{units: 2'd0, env0: ENV_MODULATE, env1: ENV_MODULATE, at_mode: 4'd0,
                     aref: 8'd0, srcf: BF_ONE, dstf: 4'd0, wmask: 4'd15};
      end else if (csr.valid) begin
         case (csr.index)
            REG_UNITS:  cfg_ff.units   <= csr.data[1:0];
            REG_ENV0:   cfg_ff.env0    <= csr.data[1:0];
            REG_ENV1:   cfg_ff.env1    <= csr.data[1:0];
            REG_ATMODE: cfg_ff.at_mode <= csr.data[3:0];
            REG_AREF:   cfg_ff.aref    <= csr.data[7:0];
            REG_SRCF:   cfg_ff.srcf    <= csr.data[3:0];
            REG_DSTF:   cfg_ff.dstf    <= csr.data[3:0];
            REG_WMASK:  cfg_ff.wmask   <= csr.data[3:0];
            default: ;
         endcase
      end
   end

   assign n_units = (cfg_ff.units < LIMIT) ? cfg_ff.units : LIMIT;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign c0 = {req.frag_alpha, req.frag_blue, req.frag_green, req.frag_red};

   ffo_env_stage u_env0 (
      .clock, .reset, .advance, .in_valid(req.valid), .enable(n_units >= 2'd1),
      .mode(cfg_ff.env0), .color_in(c0), .texel(req.texel_first),
      .carry_in(req.dest_pixel), .out_valid(v1), .color_out(c1), .carry_out(dst1)
   );

   // second texel rides along one stage
   logic [31:0] tex2_ff;
   always_ff @(posedge clock) begin
      if (advance) tex2_ff <= req.texel_second;
   end

   ffo_env_stage u_env1 (
      .clock, .reset, .advance, .in_valid(v1), .enable(n_units >= 2'd2),
      .mode(cfg_ff.env1), .color_in(c1), .texel(tex2_ff),
      .carry_in(dst1), .out_valid(v2), .color_out(c2), .carry_out(dst2)
   );

   ffo_blend u_blend (
      .clock, .reset, .advance, .cfg(cfg_ff), .in_valid(v2), .color(c2),
      .dest_pixel(dst2), .out_valid(rsp.valid), .out_pixel(rsp.out_pixel),
      .covered(rsp.covered)
   );

   `FFO_ASSERT_IMPL(a_stall_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_pixel), "rsp lost while stalled")
   `FFO_ASSERT_IMPL(a_ready, clock, reset, req.ready == (!rsp.valid || rsp.ready), "ready mismatch")
   `FFO_ASSERT_RST(a_reset, clock, reset |=> !rsp.valid, "valid after reset")
endmodule
`default_nettype wire

// File: sim/ffo_checker.sv
module ffo_checker
   import ffo_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   input  wire logic  req_ready,
   input  wire logic [7:0]  frag_red,
   input  wire logic [7:0]  frag_green,
   input  wire logic [7:0]  frag_blue,
   input  wire logic [7:0]  frag_alpha,
   input  wire logic [31:0] texel_first,
   input  wire logic [31:0] texel_second,
   input  wire logic [31:0] dest_pixel,
   input  wire logic  rsp_valid,
   input  wire logic  rsp_ready,
   input  wire logic [31:0] out_pixel,
   input  wire logic  covered,
   input  wire logic  csr_valid,
   input  wire logic  csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output int         fail_count,
   output int         pending
);
   typedef struct {
      logic [31:0] pixel;
      logic        cov;
   } frag_result_t;

   cfg_type       shadow;
   frag_result_t  pixel_queue[$];

   // unorm8 product rounding
   function automatic int unorm_div(input int x);
      return (x + 127) / 255;
   endfunction

   function automatic int blend_factor(input logic [3:0] f, input int i,
                                       input int s[4], input int d[4]);
      case (f)
         BF_ONE:      return 255;
         BF_SRC:      return s[i];
         BF_DST:      return d[i];
         BF_INV_SRC:  return 255 - s[i];
         BF_INV_DST:  return 255 - d[i];
         BF_SRC_A:    return s[3];
         BF_INV_SRCA: return 255 - s[3];
         BF_DST_A:    return d[3];
         BF_INV_DSTA: return 255 - d[3];
         BF_SAT: begin
            if (i == 3) return 255;
            return (s[3] < 255 - d[3]) ? s[3] : 255 - d[3];
         end
         default:     return 0;
      endcase
   endfunction

   function automatic void texture_env(input logic [1:0] mode, inout int c[4],
                                       input logic [31:0] tex);
      int t[4];
      for (int i = 0; i < 4; i++) t[i] = tex[8*i +: 8];
      case (mode)
         ENV_REPLACE:  for (int i = 0; i < 4; i++) c[i] = t[i];
         ENV_MODULATE: for (int i = 0; i < 4; i++) c[i] = unorm_div(c[i] * t[i]);
         ENV_DECAL:    for (int i = 0; i < 3; i++)
                          c[i] = unorm_div(c[i] * (255 - t[3]) + t[i] * t[3]);
         default: ;
      endcase
   endfunction

   function automatic frag_result_t shade_fragment();
      int c[4];
      int d[4];
      int o[4];
      int n;
      int v;
      frag_result_t r;
      c[0] = frag_red; c[1] = frag_green; c[2] = frag_blue; c[3] = frag_alpha;
      n = (shadow.units > 2) ? 2 : shadow.units;
      if (n >= 1) texture_env(shadow.env0, c, texel_first);
      if (n >= 2) texture_env(shadow.env1, c, texel_second);
      case (shadow.at_mode)
         AT_NEVER:    r.cov = 1'b0;
         AT_LESS:     r.cov = c[3] <  shadow.aref;
         AT_LEQUAL:   r.cov = c[3] <= shadow.aref;
         AT_EQUAL:    r.cov = c[3] == shadow.aref;
         AT_GEQUAL:   r.cov = c[3] >= shadow.aref;
         AT_GREATER:  r.cov = c[3] >  shadow.aref;
         AT_NOTEQUAL: r.cov = c[3] != shadow.aref;
         default:     r.cov = 1'b1;
      endcase
      d[0] = dest_pixel[23:16]; d[1] = dest_pixel[15:8];
      d[2] = dest_pixel[7:0];   d[3] = dest_pixel[31:24];
      for (int i = 0; i < 4; i++) begin
         v = unorm_div(blend_factor(shadow.srcf, i, c, d) * c[i] +
                       blend_factor(shadow.dstf, i, c, d) * d[i]);
         if (v > 255) v = 255;
         o[i] = shadow.wmask[i] ? v : d[i];
      end
      r.pixel = {o[3][7:0], o[0][7:0], o[1][7:0], o[2][7:0]};
      return r;
   endfunction

   assign pending = pixel_queue.size();

   // track registers, predict on accept, compare on result
   always @(posedge clock) begin
      frag_result_t want;
      if (reset) begin
         shadow <= '{units: 2'd0, env0: ENV_MODULATE, env1: ENV_MODULATE,
                     at_mode: 4'd0, aref: 8'd0, srcf: BF_ONE, dstf: 4'd0,
                     wmask: 4'hf};
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_UNITS:  shadow.units   <= csr_data[1:0];
               REG_ENV0:   shadow.env0    <= csr_data[1:0];
               REG_ENV1:   shadow.env1    <= csr_data[1:0];
               REG_ATMODE: shadow.at_mode <= csr_data[3:0];
               REG_AREF:   shadow.aref    <= csr_data[7:0];
               REG_SRCF:   shadow.srcf    <= csr_data[3:0];
               REG_DSTF:   shadow.dstf    <= csr_data[3:0];
               default:    shadow.wmask   <= csr_data[3:0];
            endcase
         end
         if (req_valid && req_ready) pixel_queue.push_back(shade_fragment());
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               $error("result with nothing expected: out_pixel %h", out_pixel);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_queue.pop_front();
               if (want.pixel !== out_pixel || want.cov !== covered)
                  fail_count <= fail_count + 1;
               if (want.pixel !== out_pixel)
                  $error("out_pixel expected %h actual %h", want.pixel, out_pixel);
               if (want.cov !== covered)
                  $error("covered expected %b actual %b", want.cov, covered);
            end
         end
      end
   end
endmodule

// File: sim/testbench.sv
module testbench;
   import ffo_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   bit   no_idle;

   ffo_req_if req ();
   ffo_rsp_if rsp ();
   ffo_csr_if csr ();

   fixed_function_fragment_ops u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   ffo_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .frag_red(req.frag_red), .frag_green(req.frag_green),
      .frag_blue(req.frag_blue), .frag_alpha(req.frag_alpha),
      .texel_first(req.texel_first), .texel_second(req.texel_second),
      .dest_pixel(req.dest_pixel),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .out_pixel(rsp.out_pixel), .covered(rsp.covered),
      .csr_valid(csr.valid), .csr_ready(csr.ready),
      .csr_index(csr.index), .csr_data(csr.data),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0; req.frag_red = '0; req.frag_green = '0; req.frag_blue = '0;
      req.frag_alpha = '0; req.texel_first = '0; req.texel_second = '0;
      req.dest_pixel = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
   end

   // receiver stalls at random unless in a no-idle stretch
   always @(posedge clock) begin
      rsp.ready <= no_idle || ($urandom_range(99) >= 35);
   end

   // watchdog on cycles without any accept
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("fixed_function_fragment_ops: mismatch");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic drain_pipe();
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_fragment(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a,
                                input logic [31:0] t0, input logic [31:0] t1,
                                input logic [31:0] dst);
      while (!no_idle && $urandom_range(99) < 35) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.frag_red <= r; req.frag_green <= g; req.frag_blue <= b; req.frag_alpha <= a;
      req.texel_first <= t0; req.texel_second <= t1; req.dest_pixel <= dst;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_random();
      send_fragment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // pick register values, extremes often, out-of-range codes now and then
   task automatic random_setup();
      write_reg(REG_UNITS,  $urandom_range(3));
      write_reg(REG_ENV0,   $urandom_range(3));
      write_reg(REG_ENV1,   $urandom_range(3));
      write_reg(REG_ATMODE, $urandom_range(15));
      write_reg(REG_AREF,   ($urandom_range(3) == 0) ? 255 : $urandom_range(255));
      write_reg(REG_SRCF,   $urandom_range(15));
      write_reg(REG_DSTF,   $urandom_range(15));
      write_reg(REG_WMASK,  $urandom_range(15));
   endtask

   initial begin
      no_idle = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: blending off, pass-through
      send_fragment(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
      send_fragment(8'hff, 8'hff, 8'hff, 8'hff, '1, '1, '1);
      end_burst();
      drain_pipe();

      // two units, decal then modulate, saturate blend, partial mask
      write_reg(REG_UNITS, 2'd2);
      write_reg(REG_ENV0, ENV_DECAL);
      write_reg(REG_ENV1, ENV_MODULATE);
      write_reg(REG_ATMODE, AT_GEQUAL);
      write_reg(REG_AREF, 8'h80);
      write_reg(REG_SRCF, BF_SAT);
      write_reg(REG_DSTF, BF_INV_SRCA);
      write_reg(REG_WMASK, 4'b0101);
      send_fragment(8'h10, 8'h20, 8'h30, 8'h80, 32'h80808000, 32'h8080800f, '1);
      send_fragment(8'hff, 8'h00, 8'hff, 8'h7f, 32'hff000000, 32'h00ffffff, 32'h0);
      send_fragment(8'h00, 8'hff, 8'h00, 8'hff, 32'h00000000, '1, 32'h80808080);
      end_burst();
      drain_pipe();

      // units beyond the limit, replace, env code three, never test
      write_reg(REG_UNITS, 2'd3);
      write_reg(REG_ENV0, ENV_REPLACE);
      write_reg(REG_ENV1, 2'd3);
      write_reg(REG_ATMODE, AT_NEVER);
      write_reg(REG_SRCF, 4'd15);
      write_reg(REG_DSTF, BF_ONE);
      write_reg(REG_WMASK, 4'hf);
      send_fragment(8'hff, 8'hff, 8'hff, 8'hff, '1, 32'h0, '1);
      send_fragment(8'h01, 8'h02, 8'h03, 8'h04, 32'h12345678, '1, 32'h87654321);
      end_burst();
      drain_pipe();

      // each alpha test mode against a few alphas
      write_reg(REG_UNITS, 2'd0);
      write_reg(REG_AREF, 8'h40);
      write_reg(REG_SRCF, BF_SRC_A);
      write_reg(REG_DSTF, BF_INV_DSTA);
      for (int m = 0; m <= 9; m++) begin
         write_reg(REG_ATMODE, m);
         send_fragment(8'h55, 8'haa, 8'h11, 8'h40, '0, '0, $urandom);
         send_fragment(8'h55, 8'haa, 8'h11, 8'h41, '0, '0, $urandom);
         end_burst();
         drain_pipe();
      end

      // random phases; a no-idle stretch in the middle, and a full wait
      for (int phase = 0; phase < 30; phase++) begin
         random_setup();
         no_idle = (phase == 12 || phase == 13);
         for (int k = 0; k < 25; k++) begin
            send_random();
            if (phase == 5 && k == 10) begin
               end_burst();
               while (pending != 0) @(posedge clock);
            end
         end
         end_burst();
         drain_pipe();
      end
      no_idle = 1'b0;

      drain_pipe();
      if (fail_count == 0)
         $display("fixed_function_fragment_ops: match");
      else
         $display("fixed_function_fragment_ops: mismatch");
      $finish;
   end
endmodule

// File: files.f
+incdir+hdl
hdl/ffo_pkg.sv
hdl/ffo_if.sv
hdl/ffo_env_stage.sv
hdl/ffo_blend.sv
hdl/fixed_function_fragment_ops.sv
sim/ffo_checker.sv
sim/testbench.sv
